/* hdl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/sust_pkg.sv */
// shared types and constants for the sorted unique set table
`timescale 1ns / 1ps

package sust_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_BITS    = 32;
    localparam int OP_BITS     = 3;
    localparam int ENTRY_BITS  = 7;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [CNT_W-1:0] CAP_CNT    = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_PHASE = IDX_W'(CAPACITY - 1);

    typedef logic signed [KEY_BITS-1:0] t_key;
    typedef logic [CNT_W-1:0]           t_count;

    // request codes
    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_EVENS  = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // result codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    // commands broadcast to every cell
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_COMPARE,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_MARK,
        CMD_SORT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        t_key      key;
        t_count    count;
        logic      phase;
    } t_cell_ctl;

endpackage

/* hdl/sust_cell.sv */
// one slot of the sorted store: compare, shift, keep marking and compaction swap
`timescale 1ns / 1ps

module sust_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [sust_pkg::IDX_W-1:0] i_idx,
    input  sust_pkg::t_cell_ctl        i_ctl,
    input  sust_pkg::t_key             i_left_key,
    input  logic                       i_left_lt,
    input  logic                       i_left_keep,
    input  sust_pkg::t_key             i_right_key,
    input  logic                       i_right_keep,
    output sust_pkg::t_key             o_key,
    output logic                       o_lt,
    output logic                       o_eq,
    output logic                       o_keep
);

    sust_pkg::t_key r_key;
    sust_pkg::t_key n_key;
    logic           r_lt;
    logic           r_eq;
    logic           r_keep;
    logic           n_keep;
    logic           occupied;
    logic           pair_left;

    // slot holds a live key when its index is below the count
    assign occupied  = {1'b0, i_idx} < i_ctl.count;
    // in this sort phase the cell is the left member of its pair
    assign pair_left = (i_idx[0] == i_ctl.phase);

    // next key and keep flag
    always_comb begin
        n_key  = r_key;
        n_keep = r_keep;
        case (i_ctl.cmd)
            sust_pkg::CMD_INSERT: begin
                // first slot not below the key takes it, later slots shift right
                if (!r_lt) begin
                    n_key = i_left_lt ? i_ctl.key : i_left_key;
                end
            end
            sust_pkg::CMD_REMOVE: begin
                if (!r_lt) begin
                    n_key = i_right_key;
                end
            end
            sust_pkg::CMD_MARK: begin
                n_keep = occupied & r_key[0];
            end
            sust_pkg::CMD_SORT: begin
                // move kept keys left over holes, order of kept keys preserved
                if (pair_left) begin
                    if (!r_keep && i_right_keep) begin
                        n_key  = i_right_key;
                        n_keep = 1'b1;
                    end
                end else begin
                    if (!i_left_keep && r_keep) begin
                        n_key  = i_left_key;
                        n_keep = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // key storage
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    // compare and keep flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt   <= 1'b0;
            r_eq   <= 1'b0;
            r_keep <= 1'b0;
        end else begin
            r_keep <= n_keep;
            if (i_ctl.cmd == sust_pkg::CMD_COMPARE) begin
                r_lt <= occupied && (r_key < i_ctl.key);
                r_eq <= occupied && (r_key == i_ctl.key);
            end
        end
    end

    assign o_key  = r_key;
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;
    assign o_keep = r_keep;

endmodule

/* hdl/sorted_unique_set_table.sv */
// top level: cell chain of the sorted unique set table and its sequencer
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sorted set of up to CAPACITY distinct signed keys held in a chain of cells, one key per
// cell in ascending order. One transaction is taken at a time. For insert, remove,
// search, clear and unused codes, every cell compares its key with the request key in the
// accept cycle, and in the next cycle the match flags are merged and the chain shifts one
// place right (insert) or left (remove). Remove-evens marks the odd keys to keep in its
// accept cycle, then CAPACITY odd-even phases of neighbor swaps squeeze the kept keys to
// the front, and the finish state encodes the new count. The result sits in an output
// register, so a new transaction is taken while an earlier result waits; the sequencer
// stalls only if a second result is ready before the first one is taken.

module sorted_unique_set_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [sust_pkg::OP_BITS-1:0]    i_operation,
    input  logic signed [31:0]              i_key_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic                            o_found,
    output logic [sust_pkg::ENTRY_BITS-1:0] o_entry_count
);

    localparam int CAP = sust_pkg::CAPACITY;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_SORT,
        S_FINISH,
        S_HOLD
    } t_state;

    t_state                        r_state;
    logic [sust_pkg::OP_BITS-1:0]  r_op;
    sust_pkg::t_key                r_key_arg;
    sust_pkg::t_count              r_count;
    logic [sust_pkg::IDX_W-1:0]    r_phase;
    sust_pkg::t_status             r_pend_status;
    logic                          r_pend_found;
    sust_pkg::t_count              r_pend_count;
    logic                          r_out_valid;
    sust_pkg::t_status             r_out_status;
    logic                          r_out_found;
    logic [sust_pkg::ENTRY_BITS-1:0] r_out_count;

    sust_pkg::t_cell_ctl           ctl;
    sust_pkg::t_cell_cmd           apply_cmd;
    sust_pkg::t_status             res_status;
    logic                          res_found;
    sust_pkg::t_count              res_count;
    sust_pkg::t_count              evens_count;
    logic                          in_accept;
    logic                          out_free;
    logic                          hit;
    logic                          full;

    sust_pkg::t_key                w_key       [CAP];
    sust_pkg::t_key                w_left_key  [CAP];
    sust_pkg::t_key                w_right_key [CAP];
    logic [CAP-1:0]                lt_vec;
    logic [CAP-1:0]                eq_vec;
    logic [CAP-1:0]                keep_vec;
    logic [CAP-1:0]                left_lt;
    logic [CAP-1:0]                left_keep;
    logic [CAP-1:0]                right_keep;
    logic [CAP-1:0]                boundary;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign hit       = |eq_vec;
    assign full      = (r_count == sust_pkg::CAP_CNT);

    // neighbor wiring along the chain, the head sees a smaller key on its left
    assign left_lt    = {lt_vec[CAP-2:0], 1'b1};
    assign left_keep  = {keep_vec[CAP-2:0], 1'b1};
    assign right_keep = {1'b0, keep_vec[CAP-1:1]};

    always_comb begin
        w_left_key[0]      = w_key[0];
        w_right_key[CAP-1] = w_key[CAP-1];
        for (int i = 1; i < CAP; i++) begin
            w_left_key[i]    = w_key[i-1];
            w_right_key[i-1] = w_key[i];
        end
    end

    // cell chain
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        sust_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_idx        (sust_pkg::IDX_W'(g)),
            .i_ctl        (ctl),
            .i_left_key   (w_left_key[g]),
            .i_left_lt    (left_lt[g]),
            .i_left_keep  (left_keep[g]),
            .i_right_key  (w_right_key[g]),
            .i_right_keep (right_keep[g]),
            .o_key        (w_key[g]),
            .o_lt         (lt_vec[g]),
            .o_eq         (eq_vec[g]),
            .o_keep       (keep_vec[g])
        );
    end

    // count after compaction: kept keys form a prefix, encode its end
    always_comb begin
        evens_count = '0;
        for (int i = 0; i < CAP; i++) begin
            boundary[i] = keep_vec[i] & ~right_keep[i];
            if (boundary[i]) begin
                evens_count = evens_count | sust_pkg::CNT_W'(i + 1);
            end
        end
    end

    // result and chain command of the apply and finish cycles
    always_comb begin
        apply_cmd  = sust_pkg::CMD_IDLE;
        res_status = sust_pkg::ST_DONE;
        res_found  = 1'b0;
        res_count  = r_count;
        if (r_state == S_FINISH) begin
            res_count = evens_count;
        end else begin
            case (r_op)
                sust_pkg::OP_INSERT: begin
                    if (hit) begin
                        res_status = sust_pkg::ST_DUP;
                    end else if (full) begin
                        res_status = sust_pkg::ST_FULL;
                    end else begin
                        apply_cmd = sust_pkg::CMD_INSERT;
                        res_count = r_count + 1'b1;
                    end
                end
                sust_pkg::OP_REMOVE: begin
                    if (hit) begin
                        apply_cmd = sust_pkg::CMD_REMOVE;
                        res_count = r_count - 1'b1;
                    end else begin
                        res_status = sust_pkg::ST_MISS;
                    end
                end
                sust_pkg::OP_SEARCH: begin
                    if (hit) begin
                        res_found = 1'b1;
                    end else begin
                        res_status = sust_pkg::ST_MISS;
                    end
                end
                sust_pkg::OP_CLEAR: begin
                    res_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // broadcast control to the cells
    always_comb begin
        ctl.key   = r_key_arg;
        ctl.count = r_count;
        ctl.phase = r_phase[0];
        ctl.cmd   = sust_pkg::CMD_IDLE;
        case (r_state)
            S_IDLE: begin
                ctl.key = i_key_value;
                if (in_accept) begin
                    ctl.cmd = (i_operation == sust_pkg::OP_EVENS) ?
                              sust_pkg::CMD_MARK : sust_pkg::CMD_COMPARE;
                end
            end
            S_APPLY: begin
                ctl.cmd = apply_cmd;
            end
            S_SORT: begin
                ctl.cmd = sust_pkg::CMD_SORT;
            end
            default: begin
            end
        endcase
    end

    // sequencer, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // a waiting result leaves once the receiver takes it
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                    r_phase <= '0;
                    if (in_accept) begin
                        r_op      <= i_operation;
                        r_key_arg <= i_key_value;
                        r_state   <= (i_operation == sust_pkg::OP_EVENS) ? S_SORT : S_APPLY;
                    end
                end
                S_SORT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                    r_phase <= r_phase + 1'b1;
                    if (r_phase == sust_pkg::LAST_PHASE) begin
                        r_state <= S_FINISH;
                    end
                end
                S_APPLY, S_FINISH: begin
                    r_count <= res_count;
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= res_status;
                        r_out_found  <= res_found;
                        r_out_count  <= sust_pkg::ENTRY_BITS'(res_count);
                        r_state      <= S_IDLE;
                    end else begin
                        r_pend_status <= res_status;
                        r_pend_found  <= res_found;
                        r_pend_count  <= res_count;
                        r_state       <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_pend_status;
                        r_out_found  <= r_pend_found;
                        r_out_count  <= sust_pkg::ENTRY_BITS'(r_pend_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_entry_count = r_out_count;

    // the count never passes the capacity
    `ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= sust_pkg::CAP_CNT)
    // keys are distinct, so at most one cell matches
    `ASSERT_IMPL(a_single_match, i_clk, i_rst_n, r_state == S_APPLY, $onehot0(eq_vec))
    // after compaction the kept keys form one prefix
    `ASSERT_IMPL(a_prefix_kept, i_clk, i_rst_n, r_state == S_FINISH, $onehot0(boundary))
    // a search leaves the count alone
    `ASSERT_NEXT(a_search_count, i_clk, i_rst_n,
        r_state == S_APPLY && r_op == sust_pkg::OP_SEARCH, r_count == $past(r_count))

endmodule
